[src/arpc_pkg.sv]
// Package for the ARP cache responder: constants, codes and shared types.
// No dependencies.
`default_nettype none
package arpc_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int MaxResults = 32;
  localparam int ResCntW = $clog2(MaxResults + 1);
  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] OpRequest = 16'h0001;
  localparam logic [15:0] OpReply = 16'h0002;
  localparam logic [15:0] AgeMax = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0, KIND_TICK = 2'd1, KIND_LOOKUP_IP = 2'd2, KIND_LOOKUP_MAC = 2'd3
  } kind_e;
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_REPLY = 2'd1, ACT_REQUEST = 2'd2, ACT_LOOKUP = 2'd3
  } action_e;
  typedef enum logic [2:0] {
    REG_LOCAL_IP_0 = 3'd0, REG_LOCAL_MASK_0 = 3'd1, REG_LOCAL_IP_1 = 3'd2,
    REG_LOCAL_MASK_1 = 3'd3, REG_LOCAL_COUNT = 3'd4, REG_REFRESH = 3'd5,
    REG_DELETE = 3'd6
  } reg_e;
  typedef enum logic [2:0] {
    ST_IDLE, ST_FRAME, ST_TICK_HEAD, ST_TICK_REQ, ST_EMIT
  } state_e;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] age;
  } entry_t;

  // control from sequencer into the row of cells
  typedef struct packed {
    logic   write;     // write wr_entry at wr_idx
    logic [IdxW-1:0] wr_idx;
    logic   shift;     // compact: cells at index >= shift_idx take their right neighbor
    logic [IdxW-1:0] shift_idx;
    logic   age_head;  // set head age to head_age
    logic [15:0] head_age;
  } cell_ctl_t;
endpackage
`default_nettype wire

[src/arpc_cell.sv]
// One cache entry cell of the ARP cache row.
// Depends on arpc_pkg.
`default_nettype none
module arpc_cell
  import arpc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   sel_write_i,
  input  wire entry_t wr_entry_i,
  input  wire logic   sel_shift_i,
  input  wire entry_t right_i,
  input  wire logic   sel_age_i,
  input  wire logic [15:0] age_i,
  input  wire logic [31:0] q_ip_i,
  input  wire logic [47:0] q_mac_i,
  output entry_t      entry_o,
  output logic        hit_ip_o,
  output logic        hit_mac_o
);
  entry_t e_q, e_d;
  always_comb begin
    e_d = e_q;
    if (sel_write_i) begin
      e_d = wr_entry_i;
    end else if (sel_shift_i) begin
      e_d = right_i;
    end else if (sel_age_i) begin
      e_d.age = age_i;
    end
  end
  always_ff @(posedge clk_i) begin
    e_q <= e_d;
  end
  assign entry_o = e_q;
  assign hit_ip_o = (e_q.ip == q_ip_i);
  assign hit_mac_o = (e_q.mac == q_mac_i);
endmodule
`default_nettype wire

[src/arpc_row.sv]
// Row of TableDepth entry cells; each cell hands its entry to its left neighbor on compaction.
// Depends on arpc_pkg and arpc_cell.
`default_nettype none
module arpc_row
  import arpc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire entry_t    wr_entry_i,
  input  wire logic [31:0] q_ip_i,
  input  wire logic [47:0] q_mac_i,
  output entry_t         head_o,
  output logic [TableDepth-1:0] hit_ip_o,
  output logic [TableDepth-1:0] hit_mac_o,
  output entry_t         entries_o [TableDepth]
);
  entry_t ent [TableDepth];
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    entry_t right;
    if (g == TableDepth - 1) begin : g_end
      assign right = ent[g];
    end else begin : g_mid
      assign right = ent[g+1];
    end
    arpc_cell u_cell (
      .clk_i      (clk_i),
      .sel_write_i(ctl_i.write && ctl_i.wr_idx == IdxW'(g)),
      .wr_entry_i (wr_entry_i),
      .sel_shift_i(ctl_i.shift && IdxW'(g) >= ctl_i.shift_idx),
      .right_i    (right),
      .sel_age_i  (ctl_i.age_head && ctl_i.shift_idx == IdxW'(g)),
      .age_i      (ctl_i.head_age),
      .q_ip_i     (q_ip_i),
      .q_mac_i    (q_mac_i),
      .entry_o    (ent[g]),
      .hit_ip_o   (hit_ip_o[g]),
      .hit_mac_o  (hit_mac_o[g])
    );
  end
  assign head_o = ent[ctl_i.shift_idx];
  assign entries_o = ent;
endmodule
`default_nettype wire

[src/arp_cache_responder.sv]
// ARP cache responder: 16-entry row of cells, frame/lookup handling, tick aging.
// Sequence: frame/lookup goes through ST_FRAME to a registered result; tick walks the entries
// in ST_TICK_HEAD, with one ST_TICK_REQ step per active local address for each stale entry.
// Throughput: one item at a time; next item accepted once the last result is taken.
// Reset: asynchronous active low; clears control state and registers; entries are
// not cleared, only those below the entry count are read.
// Depends on arpc_pkg, arpc_row.
`default_nettype none
module arp_cache_responder
  import arpc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: ether_type[15:0], arp_opcode[31:16], sender_mac[79:32], sender_ip[111:80],
  // target_ip[143:112], bypass_filter[144], query_ip[176:145], query_mac[224:177], pad
  input  wire logic [231:0] s_axis_tdata,
  // tuser: kind
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: found[0], peer_mac[48:1], peer_ip[80:49], source_ip[112:81], pad
  output logic [119:0]      m_axis_tdata,
  // tuser: action
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  logic [31:0] lip_q [2];
  logic [31:0] lmask_q [2];
  logic [1:0]  lcnt_q;
  logic [15:0] refresh_q, delete_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lip_q[0] <= '0; lip_q[1] <= '0;
      lmask_q[0] <= 32'hFFFFFF00; lmask_q[1] <= 32'hFFFFFF00;
      lcnt_q <= '0; refresh_q <= 16'd60; delete_q <= 16'd120;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_LOCAL_IP_0:   lip_q[0] <= cfg_data_i;
        REG_LOCAL_MASK_0: lmask_q[0] <= cfg_data_i;
        REG_LOCAL_IP_1:   lip_q[1] <= cfg_data_i;
        REG_LOCAL_MASK_1: lmask_q[1] <= cfg_data_i;
        REG_LOCAL_COUNT:  lcnt_q <= cfg_data_i[1:0];
        REG_REFRESH:      refresh_q <= cfg_data_i[15:0];
        REG_DELETE:       delete_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end
  logic [1:0] act_n;
  assign act_n = (lcnt_q > 2'd2) ? 2'd2 : lcnt_q;

  // input word register
  logic [1:0]  kind_q;
  logic [15:0] ether_q, op_q;
  logic [47:0] smac_q, qmac_q;
  logic [31:0] sip_q, tip_q, qip_q;
  logic        byp_q;

  state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] rp_q, rp_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [15:0] age_q, age_d;
  logic        j_q, j_d;
  logic [ResCntW-1:0] nres_q, nres_d;
  logic [1:0]  oact_q, oact_d;
  logic        ofound_q, ofound_d, olast_q, olast_d, ovalid_q, ovalid_d;
  logic [47:0] omac_q, omac_d;
  logic [31:0] oip_q, oip_d, osrc_q, osrc_d;

  cell_ctl_t ctl;
  entry_t    wr_e, head;
  logic [TableDepth-1:0] hip, hmac;
  entry_t    ents [TableDepth];

  arpc_row u_row (
    .clk_i(clk_i), .ctl_i(ctl), .wr_entry_i(wr_e),
    .q_ip_i((kind_q == KIND_FRAME) ? sip_q : qip_q), .q_mac_i(qmac_q),
    .head_o(head), .hit_ip_o(hip), .hit_mac_o(hmac), .entries_o(ents)
  );

  logic [TableDepth-1:0] vmask, mip, mmac;
  logic        any_ip, any_mac;
  logic [IdxW-1:0] ip_idx, mac_idx;
  always_comb begin
    for (int i = 0; i < TableDepth; i++) vmask[i] = (CntW'(i) < cnt_q);
    mip = hip & vmask;
    mmac = hmac & vmask;
    any_ip = |mip; any_mac = |mmac;
    ip_idx = '0; mac_idx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (mip[i]) ip_idx = IdxW'(i);
      if (mmac[i]) mac_idx = IdxW'(i);
    end
  end

  logic pass;
  assign pass = byp_q || (act_n >= 2'd1 && lip_q[0] == tip_q)
                      || (act_n == 2'd2 && lip_q[1] == tip_q);

  logic accept_in;
  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
  assign accept_in = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q <= s_axis_tuser;
      ether_q <= s_axis_tdata[15:0];
      op_q <= s_axis_tdata[31:16];
      smac_q <= s_axis_tdata[79:32];
      sip_q <= s_axis_tdata[111:80];
      tip_q <= s_axis_tdata[143:112];
      byp_q <= s_axis_tdata[144];
      qip_q <= s_axis_tdata[176:145];
      qmac_q <= s_axis_tdata[224:177];
    end
  end

  // current tick entry
  logic [15:0] inc_age;
  logic        match_j, stale;
  assign inc_age = (head.age == AgeMax) ? head.age : head.age + 16'd1;
  assign match_j = ((head.ip & lmask_q[j_q]) == (lip_q[j_q] & lmask_q[j_q]))
                   && ({1'b0, j_q} < act_n);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rp_d = rp_q; idx_d = idx_q; age_d = age_q;
    j_d = j_q; nres_d = nres_q;
    oact_d = oact_q; ofound_d = ofound_q; omac_d = omac_q; oip_d = oip_q;
    osrc_d = osrc_q; olast_d = olast_q; ovalid_d = ovalid_q;
    ctl = '0; ctl.shift_idx = idx_q[IdxW-1:0]; ctl.head_age = inc_age;
    wr_e.ip = sip_q; wr_e.mac = smac_q; wr_e.age = '0;
    stale = inc_age > refresh_q;
    if (m_axis_tvalid && m_axis_tready) ovalid_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (accept_in) begin
          st_d = (s_axis_tuser == KIND_TICK) ? ST_TICK_HEAD : ST_FRAME;
          idx_d = '0; nres_d = '0;
        end
      end
      ST_FRAME: begin
        st_d = ST_EMIT;
        oact_d = ACT_NONE; ofound_d = 1'b0; omac_d = '0; oip_d = '0; osrc_d = '0;
        olast_d = 1'b1;
        case (kind_e'(kind_q))
          KIND_FRAME: begin
            if (ether_q == EtherTypeArp && pass && (op_q == OpRequest || op_q == OpReply)) begin
              ctl.write = 1'b1;
              if (any_ip) begin
                ctl.wr_idx = ip_idx;
              end else if (cnt_q < CntW'(TableDepth)) begin
                ctl.wr_idx = cnt_q[IdxW-1:0];
                cnt_d = cnt_q + 1'b1;
              end else begin
                ctl.wr_idx = rp_q;
                rp_d = rp_q + 1'b1;
              end
              if (op_q == OpRequest) begin
                oact_d = ACT_REPLY; omac_d = smac_q; oip_d = sip_q; osrc_d = tip_q;
              end
            end
          end
          KIND_LOOKUP_IP: begin
            oact_d = ACT_LOOKUP; ofound_d = any_ip;
            omac_d = any_ip ? ents[ip_idx].mac : '0;
          end
          KIND_LOOKUP_MAC: begin
            oact_d = ACT_LOOKUP; ofound_d = any_mac;
            oip_d = any_mac ? ents[mac_idx].ip : '0;
          end
          default: ;
        endcase
        ovalid_d = 1'b1;
      end
      ST_TICK_HEAD: begin
        // idx_q addresses the entry at the head of the walk
        if (idx_q >= cnt_q) begin
          st_d = ST_EMIT;
          if (nres_q == '0) begin
            oact_d = ACT_NONE; ofound_d = 1'b0; omac_d = '0; oip_d = '0; osrc_d = '0;
            olast_d = 1'b1; ovalid_d = 1'b1;
          end else begin
            // the held request becomes the final word
            olast_d = 1'b1;
          end
        end else begin
          age_d = inc_age;
          ctl.age_head = 1'b1;
          j_d = 1'b0;
          if (stale && act_n != 2'd0) begin
            st_d = ST_TICK_REQ;
          end else if (inc_age > delete_q) begin
            ctl.age_head = 1'b0; ctl.shift = 1'b1; cnt_d = cnt_q - 1'b1;
            age_d = head.age;
          end else begin
            idx_d = idx_q + 1'b1;
          end
          if (!(stale && act_n != 2'd0)) age_d = '0;
        end
      end
      ST_TICK_REQ: begin
        // age_q holds the new age of the head entry; emit one request per matching local
        stale = 1'b1;
        if (!match_j || nres_q == ResCntW'(MaxResults) || !ovalid_q || m_axis_tready) begin
          if (match_j && nres_q != ResCntW'(MaxResults)) begin
            if (!ovalid_d) begin
              // flush held word first, then this becomes the held one
              oact_d = ACT_REQUEST; ofound_d = 1'b0; omac_d = '0; oip_d = head.ip;
              osrc_d = lip_q[j_q]; olast_d = 1'b0; ovalid_d = 1'b1;
              nres_d = nres_q + 1'b1;
            end
          end
          if (!match_j || nres_q == ResCntW'(MaxResults) || !ovalid_d
              || nres_d != nres_q) begin
            if (j_q == 1'b0 && act_n == 2'd2) begin
              j_d = 1'b1;
            end else begin
              st_d = ST_TICK_HEAD;
              if (age_q > delete_q) begin
                ctl.shift = 1'b1; cnt_d = cnt_q - 1'b1;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (!ovalid_d) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // held request waits unmarked; tick end sets last on it (or emits a final word)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; rp_q <= '0; idx_q <= '0; age_q <= '0;
      j_q <= 1'b0; nres_q <= '0; ovalid_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rp_q <= rp_d; idx_q <= idx_d; age_q <= age_d;
      j_q <= j_d; nres_q <= nres_d; ovalid_q <= ovalid_d; olast_q <= olast_d;
    end
  end
  always_ff @(posedge clk_i) begin
    oact_q <= oact_d; ofound_q <= ofound_d; omac_q <= omac_d;
    oip_q <= oip_d; osrc_q <= osrc_d;
  end

  // a tick's last request is held until the walk ends, so it can take last;
  // it shows once a further request is ready to replace it
  logic hold_last;
  assign hold_last = !olast_q && (st_q == ST_TICK_HEAD
                     || (st_q == ST_TICK_REQ
                         && !(match_j && nres_q != ResCntW'(MaxResults))));
  assign m_axis_tvalid = ovalid_q && !hold_last;
  assign m_axis_tuser  = oact_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {7'd0, osrc_q, oip_q, omac_q, ofound_q};

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableDepth)) else $error("entry count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> st_q != ST_IDLE) else $error("accepted word not processed");
  a_res_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= ResCntW'(MaxResults)) else $error("too many results");
endmodule
`default_nettype wire
